// ===== sv/heightfield_wave_step_assert.svh =====
// Assertion macros shared by the height-field wave step RTL.
// Depends on nothing; users supply clk_i and rst_ni in the including scope.
`ifndef HEIGHTFIELD_WAVE_STEP_ASSERT_SVH
`define HEIGHTFIELD_WAVE_STEP_ASSERT_SVH
`ifndef SYNTHESIS
`define HWS_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("heightfield_wave_step assertion failed");
`define HWS_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("heightfield_wave_step assertion failed");
`else
`define HWS_ASSERT(lbl, prop)
`define HWS_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ===== sv/hws_pkg.sv =====
// Shared types and constants of the height-field wave step block.
// Depends on nothing; used by hws_ctrl, hws_datapath and the top level.
package hws_pkg;

  localparam int unsigned GRID_SIZE_DEF   = 128;
  localparam int unsigned HEIGHT_BITS_DEF = 16;
  localparam int unsigned COEF_BITS       = 18;
  localparam int unsigned FIELD_BITS      = 16;
  localparam int unsigned POS_BITS        = 7;
  localparam int unsigned KIND_BITS       = 2;
  localparam int unsigned CELL_BITS       = 9;
  localparam int unsigned CFG_IDX_BITS    = 1;
  localparam int unsigned DAMP_BITS       = 15;
  localparam int unsigned DAMP_MAX        = 31130;
  localparam int unsigned DAMP_SCALE      = 311296;
  localparam int unsigned FRAC_SHIFT      = 29;

  localparam logic signed [COEF_BITS-1:0] A_COEF_RST = 18'sd4096;
  localparam logic signed [COEF_BITS-1:0] B_COEF_RST = 18'sd16384;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_DISTURB = 2'd0,
    KIND_STEP    = 2'd1,
    KIND_READ    = 2'd2
  } kind_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_A_COEF = 1'b0,
    REG_B_COEF = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [KIND_BITS-1:0]         kind;
    logic [POS_BITS-1:0]          row;
    logic [POS_BITS-1:0]          col;
    logic signed [FIELD_BITS-1:0] amount;
  } item_t;

  typedef struct packed {
    logic signed [FIELD_BITS-1:0] height;
    logic [KIND_BITS-1:0]         done_kind;
  } result_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_RD_CTR,
    OP_RD_NB,
    OP_MUL,
    OP_SUM,
    OP_DAMP,
    OP_WB,
    OP_FIN
  } op_e;

  typedef struct packed {
    op_e                          op;
    logic                         sel;
    logic                         nb_valid;
    logic [CELL_BITS-1:0]         row;
    logic [CELL_BITS-1:0]         col;
    logic [KIND_BITS-1:0]         kind;
    logic                         in_grid;
    logic signed [FIELD_BITS-1:0] amount;
  } dp_cmd_t;

endpackage

// ===== sv/hws_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module hws_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/hws_datapath.sv =====
// Datapath: the two height banks, coefficient registers, update arithmetic
// and the result register. Depends on hws_pkg and hws_ram.
module hws_datapath #(
  parameter int unsigned GRID_SIZE   = 128,
  parameter int unsigned HEIGHT_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        cfg_valid_i,
  input  logic [hws_pkg::CFG_IDX_BITS-1:0]            cfg_index_i,
  input  logic signed [hws_pkg::COEF_BITS-1:0]        cfg_data_i,
  input  hws_pkg::dp_cmd_t                            cmd_i,
  output hws_pkg::result_t                            out_data_o
);
  import hws_pkg::*;

  localparam int unsigned RW    = $clog2(GRID_SIZE);
  localparam int unsigned AW    = 2 * RW;
  localparam int unsigned DEPTH = 1 << AW;
  localparam int unsigned HB    = HEIGHT_BITS;
  localparam int unsigned NW    = HB + 2;
  localparam int unsigned MAW   = COEF_BITS + NW;
  localparam int unsigned MBW   = COEF_BITS + HB;
  localparam int unsigned TW    = (HB + 21 > 31) ? HB + 21 : 31;
  localparam int unsigned HIW   = TW - FRAC_SHIFT;
  localparam int unsigned PHW   = HIW + DAMP_BITS + 1;
  localparam int unsigned PLW   = FRAC_SHIFT + DAMP_BITS;
  localparam int unsigned RSW   = PHW + 1;
  localparam int unsigned SW    = ((HB > FIELD_BITS) ? HB : FIELD_BITS) + 1;
  localparam int unsigned HALF  = (GRID_SIZE + 1) / 2;
  localparam int unsigned DIW   = $clog2(HALF);
  localparam logic [RW-1:0] LAST = RW'(GRID_SIZE - 1);
  localparam logic signed [RSW-1:0] R_MAX = RSW'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [RSW-1:0] R_MIN = ~R_MAX;
  localparam logic signed [SW-1:0]  S_MAX = SW'((64'sd1 <<< (HB - 1)) - 64'sd1);
  localparam logic signed [SW-1:0]  S_MIN = ~S_MAX;

  typedef struct packed {
    logic ctr;
    logic nb;
    logic nb_valid;
    logic sel;
  } rd_tag_t;

  logic signed [COEF_BITS-1:0] a_q, b_q;
  rd_tag_t                     tag_q;
  logic signed [HB-1:0]        h_q, p_q;
  logic signed [NW-1:0]        nsum_q;
  logic signed [MAW-1:0]       ma_q;
  logic signed [MBW-1:0]       mb_q;
  logic signed [HB-1:0]        mp_q;
  logic [DAMP_BITS-1:0]        damp_q;
  logic signed [TW-1:0]        t_q;
  logic signed [PHW-1:0]       ph_q;
  logic [PLW-1:0]              pl_q;
  result_t                     out_q;

  logic [AW-1:0]         addr;
  logic                  we_a, we_b;
  logic [HB-1:0]         wdata;
  logic [HB-1:0]         rd_a, rd_b;
  logic signed [HB-1:0]  cur_rd, prv_rd;
  logic [RW-1:0]         rr, cc, rr_m, cc_m, d_rc, d_cc, min_dist;
  logic [DAMP_BITS-1:0]  damp_tab [HALF];
  logic [PLW:0]          rnd_full;
  logic signed [RSW-1:0] rsum;
  logic signed [HB-1:0]  res_sat;
  logic signed [SW-1:0]  dsum;
  logic signed [HB-1:0]  dist_sat;
  logic signed [HB-1:0]  rep_h;
  logic signed [31:0]    rep_ext;
  logic signed [HIW-1:0] hi;

  for (genvar g = 0; g < HALF; g++) begin : g_damp
    localparam int unsigned QV = (DAMP_SCALE * g + GRID_SIZE / 2) / GRID_SIZE;
    assign damp_tab[g] = DAMP_BITS'((QV > DAMP_MAX) ? DAMP_MAX : QV);
  end

  assign addr = {cmd_i.row[RW-1:0], cmd_i.col[RW-1:0]};

  // Distance to the nearest edge selects the damping factor.
  always_comb begin
    rr       = cmd_i.row[RW-1:0];
    cc       = cmd_i.col[RW-1:0];
    rr_m     = LAST - rr;
    cc_m     = LAST - cc;
    d_rc     = (rr < rr_m) ? rr : rr_m;
    d_cc     = (cc < cc_m) ? cc : cc_m;
    min_dist = (d_rc < d_cc) ? d_rc : d_cc;
  end

  assign cur_rd = tag_q.sel ? $signed(rd_b) : $signed(rd_a);
  assign prv_rd = tag_q.sel ? $signed(rd_a) : $signed(rd_b);

  assign hi       = t_q[TW-1:FRAC_SHIFT];
  assign rnd_full = ((PLW + 1)'(pl_q) + ((PLW + 1)'(1) << (FRAC_SHIFT - 1))) >> FRAC_SHIFT;
  assign rsum     = RSW'(ph_q) + RSW'($signed({1'b0, rnd_full[DAMP_BITS-1:0]}));
  assign dsum     = SW'(h_q) + SW'(cmd_i.amount);

  always_comb begin
    if (rsum > R_MAX) begin
      res_sat = R_MAX[HB-1:0];
    end else if (rsum < R_MIN) begin
      res_sat = R_MIN[HB-1:0];
    end else begin
      res_sat = rsum[HB-1:0];
    end
    if (dsum > S_MAX) begin
      dist_sat = S_MAX[HB-1:0];
    end else if (dsum < S_MIN) begin
      dist_sat = S_MIN[HB-1:0];
    end else begin
      dist_sat = dsum[HB-1:0];
    end
    rep_h   = (cmd_i.kind == KIND_DISTURB) ? dist_sat : h_q;
    rep_ext = 32'(rep_h);
  end

  always_comb begin
    we_a  = 1'b0;
    we_b  = 1'b0;
    wdata = '0;
    unique case (cmd_i.op)
      OP_CLEAR: begin
        we_a = 1'b1;
        we_b = 1'b1;
      end
      OP_WB: begin
        wdata = res_sat;
        we_a  = cmd_i.sel;
        we_b  = !cmd_i.sel;
      end
      OP_FIN: begin
        wdata = dist_sat;
        if (cmd_i.kind == KIND_DISTURB && cmd_i.in_grid) begin
          we_a = !cmd_i.sel;
          we_b = cmd_i.sel;
        end
      end
      default: begin
      end
    endcase
  end

  hws_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_bank_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (addr),
    .wdata_i (wdata),
    .raddr_i (addr),
    .rdata_o (rd_a)
  );

  hws_ram #(.WIDTH(HB), .DEPTH(DEPTH)) u_bank_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (addr),
    .wdata_i (wdata),
    .raddr_i (addr),
    .rdata_o (rd_b)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_q   <= A_COEF_RST;
      b_q   <= B_COEF_RST;
      tag_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_A_COEF: a_q <= cfg_data_i;
          REG_B_COEF: b_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
      tag_q.ctr      <= (cmd_i.op == OP_RD_CTR);
      tag_q.nb       <= (cmd_i.op == OP_RD_NB);
      tag_q.nb_valid <= cmd_i.nb_valid;
      tag_q.sel      <= cmd_i.sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (tag_q.ctr) begin
      h_q <= cur_rd;
      p_q <= prv_rd;
    end
    if (cmd_i.op == OP_RD_CTR) begin
      nsum_q <= '0;
    end else if (tag_q.nb && tag_q.nb_valid) begin
      nsum_q <= nsum_q + NW'(cur_rd);
    end
    unique case (cmd_i.op)
      OP_MUL: begin
        ma_q   <= MAW'(a_q) * MAW'(nsum_q);
        mb_q   <= MBW'(b_q) * MBW'(h_q);
        mp_q   <= p_q;
        damp_q <= damp_tab[min_dist[DIW-1:0]];
      end
      OP_SUM: begin
        t_q <= TW'(ma_q) + TW'(mb_q) - (TW'(mp_q) <<< 14);
      end
      OP_DAMP: begin
        ph_q <= PHW'(hi) * PHW'($signed({1'b0, damp_q}));
        pl_q <= PLW'(damp_q) * PLW'(t_q[FRAC_SHIFT-1:0]);
      end
      OP_FIN: begin
        out_q.height    <= cmd_i.in_grid ? rep_ext[FIELD_BITS-1:0] : '0;
        out_q.done_kind <= cmd_i.kind;
      end
      default: begin
      end
    endcase
  end

  assign out_data_o = out_q;

endmodule

// ===== sv/hws_ctrl.sv =====
// Controller: sequences the clearing pass, the per-cell step sweep and
// item completion. Depends on hws_pkg and the assertion macro header.
`include "heightfield_wave_step_assert.svh"
module hws_ctrl #(
  parameter int unsigned GRID_SIZE = 128
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  hws_pkg::item_t   in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output hws_pkg::dp_cmd_t cmd_o
);
  import hws_pkg::*;

  localparam int unsigned RW = $clog2(GRID_SIZE);
  localparam logic [RW-1:0] LAST = RW'(GRID_SIZE - 1);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_CTR, ST_UP, ST_DN, ST_LF, ST_RT, ST_WAIT,
    ST_MUL, ST_SUM, ST_DAMP, ST_WB, ST_ITEM, ST_IWAIT, ST_FIN, ST_DONE
  } state_e;

  state_e        state_q;
  logic [RW-1:0] r_q, c_q;
  logic          sel_q;
  logic          out_valid_q;
  item_t         item_q;
  dp_cmd_t       cmd_q;

  logic                 in_grid;
  logic [KIND_BITS-1:0] kind_norm;

  assign in_grid = ({25'd0, item_q.row} < 32'(GRID_SIZE)) &&
                   ({25'd0, item_q.col} < 32'(GRID_SIZE));

  always_comb begin
    priority if (item_q.kind == KIND_STEP) begin
      kind_norm = KIND_STEP;
    end else if (item_q.kind == KIND_DISTURB) begin
      kind_norm = KIND_DISTURB;
    end else begin
      kind_norm = KIND_READ;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      r_q         <= '0;
      c_q         <= '0;
      sel_q       <= 1'b0;
      out_valid_q <= 1'b0;
      item_q      <= '0;
      cmd_q       <= '0;
    end else begin
      cmd_q.op       <= OP_NONE;
      cmd_q.sel      <= sel_q;
      cmd_q.nb_valid <= 1'b0;
      cmd_q.row      <= CELL_BITS'(r_q);
      cmd_q.col      <= CELL_BITS'(c_q);
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          cmd_q.op <= OP_CLEAR;
          if (c_q == '1) begin
            c_q <= '0;
            if (r_q == '1) begin
              r_q     <= '0;
              state_q <= ST_IDLE;
            end else begin
              r_q <= r_q + 1'b1;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            item_q  <= in_data_i;
            r_q     <= '0;
            c_q     <= '0;
            state_q <= (in_data_i.kind == KIND_STEP) ? ST_CTR : ST_ITEM;
          end
        end
        ST_CTR: begin
          cmd_q.op <= OP_RD_CTR;
          state_q  <= ST_UP;
        end
        ST_UP: begin
          cmd_q.op       <= OP_RD_NB;
          cmd_q.row      <= CELL_BITS'(r_q - 1'b1);
          cmd_q.nb_valid <= (r_q != '0);
          state_q        <= ST_DN;
        end
        ST_DN: begin
          cmd_q.op       <= OP_RD_NB;
          cmd_q.row      <= CELL_BITS'(r_q + 1'b1);
          cmd_q.nb_valid <= (r_q != LAST);
          state_q        <= ST_LF;
        end
        ST_LF: begin
          cmd_q.op       <= OP_RD_NB;
          cmd_q.col      <= CELL_BITS'(c_q - 1'b1);
          cmd_q.nb_valid <= (c_q != '0);
          state_q        <= ST_RT;
        end
        ST_RT: begin
          cmd_q.op       <= OP_RD_NB;
          cmd_q.col      <= CELL_BITS'(c_q + 1'b1);
          cmd_q.nb_valid <= (c_q != LAST);
          state_q        <= ST_WAIT;
        end
        ST_WAIT: state_q <= ST_MUL;
        ST_MUL: begin
          cmd_q.op <= OP_MUL;
          state_q  <= ST_SUM;
        end
        ST_SUM: begin
          cmd_q.op <= OP_SUM;
          state_q  <= ST_DAMP;
        end
        ST_DAMP: begin
          cmd_q.op <= OP_DAMP;
          state_q  <= ST_WB;
        end
        ST_WB: begin
          cmd_q.op <= OP_WB;
          state_q  <= ST_CTR;
          if (c_q == LAST) begin
            c_q <= '0;
            if (r_q == LAST) begin
              r_q     <= '0;
              sel_q   <= ~sel_q;
              state_q <= ST_ITEM;
            end else begin
              r_q <= r_q + 1'b1;
            end
          end else begin
            c_q <= c_q + 1'b1;
          end
        end
        ST_ITEM: begin
          cmd_q.op  <= OP_RD_CTR;
          cmd_q.row <= CELL_BITS'(item_q.row);
          cmd_q.col <= CELL_BITS'(item_q.col);
          state_q   <= ST_IWAIT;
        end
        ST_IWAIT: state_q <= ST_FIN;
        ST_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            cmd_q.op      <= OP_FIN;
            cmd_q.row     <= CELL_BITS'(item_q.row);
            cmd_q.col     <= CELL_BITS'(item_q.col);
            cmd_q.kind    <= kind_norm;
            cmd_q.in_grid <= in_grid;
            cmd_q.amount  <= item_q.amount;
            state_q       <= ST_DONE;
          end
        end
        ST_DONE: begin
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign cmd_o       = cmd_q;

  `HWS_ASSERT(a_accept_leaves_idle, in_valid_i && in_ready_o |=> state_q != ST_IDLE)
  `HWS_ASSERT(a_sel_only_at_sweep_end, state_q != ST_WB |=> $stable(sel_q))
  `HWS_ASSERT(a_done_has_free_slot, state_q == ST_DONE |-> !out_valid_q)
  `HWS_ASSERT(a_done_raises_valid, state_q == ST_DONE |=> out_valid_q)

endmodule

// ===== sv/heightfield_wave_step.sv =====
// A read or disturb item runs ST_ITEM, ST_IWAIT, ST_FIN and ST_DONE, and
// ST_FIN waits while an earlier result is untaken. A step visits each cell
// in turn (5 reads of the current bank through its single read port, then
// multiply, sum, damp and write back), then ends like a read. One item is in
// work at a time. Reset clears all 2^(2*clog2(N)) cells of both banks (16384
// for N = 128); no item is taken meanwhile, configuration writes always are.
// Top level of the height-field wave step block.
// Depends on hws_pkg, hws_ctrl and hws_datapath.
module heightfield_wave_step #(
  parameter int unsigned GRID_SIZE   = hws_pkg::GRID_SIZE_DEF,
  parameter int unsigned HEIGHT_BITS = hws_pkg::HEIGHT_BITS_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  // Item transactions: disturb, step or read.
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  hws_pkg::item_t                       in_data_i,
  // One result transaction per item.
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output hws_pkg::result_t                     out_data_o,
  // Coefficient writes: index 0 is a_coef, index 1 is b_coef.
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [hws_pkg::CFG_IDX_BITS-1:0]     cfg_index_i,
  input  logic signed [hws_pkg::COEF_BITS-1:0] cfg_data_i
);
  import hws_pkg::*;

  dp_cmd_t cmd;

  // Coefficient registers take a write in any cycle.
  assign cfg_ready_o = 1'b1;

  // The controller walks the grid and issues one command per cycle; the
  // datapath owns the banks and does all arithmetic on those commands.
  hws_ctrl #(.GRID_SIZE(GRID_SIZE)) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  hws_datapath #(.GRID_SIZE(GRID_SIZE), .HEIGHT_BITS(HEIGHT_BITS)) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .out_data_o  (out_data_o)
  );

endmodule
